// ----- src/ccrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character-class run tokenizer package
// Shared widths, byte codes, run-state codes and the interface structs used
// between the classifier, the tokenizer core and the top level.
// ----------------------------------------------------------------------------
package ccrt_pkg;

    // Field widths of the result items.
    localparam int LEN_W = 20;
    localparam int OFF_W = 20;
    localparam int POS_W = 21;

    // Source size limit; byte offsets stop at the smaller of this minus one
    // and the largest value the offset field can hold.
    localparam longint MAX_SOURCE_BYTES = 1048576;
    localparam longint OFF_FIELD_MAX    = (longint'(1) << OFF_W) - 1;
    localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'(
        (MAX_SOURCE_BYTES - 1) < OFF_FIELD_MAX ? (MAX_SOURCE_BYTES - 1) : OFF_FIELD_MAX);

    // Saturation points for length and position counters.
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(1) << (POS_W - 1);
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

    // Input kind codes.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Result kind codes.
    localparam logic RK_TOKEN = 1'b0;
    localparam logic RK_ERROR = 1'b1;

    // Run state codes: idle, pending run of one of four classes, halted.
    localparam logic [2:0] RUN_IDLE  = 3'd0;
    localparam logic [2:0] RUN_IDENT = 3'd1;
    localparam logic [2:0] RUN_NUM   = 3'd2;
    localparam logic [2:0] RUN_QUOTE = 3'd3;
    localparam logic [2:0] RUN_OPER  = 3'd4;
    localparam logic [2:0] RUN_HALT  = 3'd5;

    // Byte codes with special meaning.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // Classification of one input item.
    typedef struct packed {
        logic       is_end;
        logic       is_newline;
        logic       is_blank;
        logic [2:0] run_code;   // RUN_IDLE when the byte has no class
    } ccrt_class_t;

    // Result produced by one step.
    typedef struct packed {
        logic             emit;
        logic             result_kind;
        logic [1:0]       token_class;
        logic [LEN_W-1:0] token_length;
        logic [OFF_W-1:0] start_offset;
        logic [POS_W-1:0] line_number;
        logic [POS_W-1:0] column_number;
    } ccrt_result_t;

endpackage

// ----- src/ccrt_classify.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character classifier
// Decodes one input item into end, newline and blank flags and a run class.
// ----------------------------------------------------------------------------
module ccrt_classify
(
    input  logic                 kind,
    input  logic [7:0]           char_byte,
    output ccrt_pkg::ccrt_class_t cls
);

    logic [2:0] run_code;

    // Map the byte to its character class.
    always_comb
    begin
        unique case (char_byte) inside
            [8'h61:8'h7A], [8'h41:8'h5A], ccrt_pkg::CH_UNDER, ccrt_pkg::CH_DOLLAR,
            [8'h80:8'hFF]:
                run_code = ccrt_pkg::RUN_IDENT;
            [8'h30:8'h39]:
                run_code = ccrt_pkg::RUN_NUM;
            ccrt_pkg::CH_DQUOTE, ccrt_pkg::CH_SQUOTE:
                run_code = ccrt_pkg::RUN_QUOTE;
            // + - * / = ! < > & | ? . , ; : % ( ) { } [ ]
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h21, 8'h3C, 8'h3E, 8'h26, 8'h7C,
            8'h3F, 8'h2E, 8'h2C, 8'h3B, 8'h3A, 8'h25, 8'h28, 8'h29, 8'h7B, 8'h7D,
            8'h5B, 8'h5D:
                run_code = ccrt_pkg::RUN_OPER;
            default:
                run_code = ccrt_pkg::RUN_IDLE;
        endcase
    end

    // A zero byte counts as an end item.
    assign cls.is_end     = (kind == ccrt_pkg::KIND_END) || (char_byte == ccrt_pkg::CH_NUL);
    assign cls.is_newline = (char_byte == ccrt_pkg::CH_LF);
    assign cls.is_blank   = (char_byte == ccrt_pkg::CH_SPACE) ||
                            (char_byte == ccrt_pkg::CH_TAB) ||
                            (char_byte == ccrt_pkg::CH_CR);
    assign cls.run_code   = run_code;

endmodule

// ----- src/ccrt_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer core
// Holds the pending run and the source position, and on each step works out
// the next state and at most one token or error result.
// ----------------------------------------------------------------------------
module ccrt_core
#(
    parameter longint MAX_SOURCE_BYTES = ccrt_pkg::MAX_SOURCE_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  ccrt_pkg::ccrt_class_t  cls,
    output ccrt_pkg::ccrt_result_t res
);

    // Byte offsets stop at the smaller of the source limit minus one and the
    // largest value the offset field can hold.
    localparam longint OFF_LIMIT_FULL =
        ((MAX_SOURCE_BYTES - 1) < ccrt_pkg::OFF_FIELD_MAX) ? (MAX_SOURCE_BYTES - 1)
                                                           : ccrt_pkg::OFF_FIELD_MAX;
    localparam logic [ccrt_pkg::OFF_W-1:0] OFF_LIMIT = OFF_LIMIT_FULL[ccrt_pkg::OFF_W-1:0];

    logic [2:0]                   run_class_reg,  run_class_next;
    logic [ccrt_pkg::LEN_W-1:0]   run_length_reg, run_length_next;
    logic [ccrt_pkg::OFF_W-1:0]   run_off_reg,    run_off_next;
    logic [ccrt_pkg::POS_W-1:0]   run_line_reg,   run_line_next;
    logic [ccrt_pkg::POS_W-1:0]   run_col_reg,    run_col_next;
    logic [ccrt_pkg::POS_W-1:0]   cur_line_reg,   cur_line_next;
    logic [ccrt_pkg::POS_W-1:0]   cur_col_reg,    cur_col_next;
    logic [ccrt_pkg::OFF_W-1:0]   byte_off_reg,   byte_off_next;

    logic                         pending;
    logic [2:0]                   token_code;
    logic [ccrt_pkg::LEN_W-1:0]   len_inc;
    logic [ccrt_pkg::POS_W-1:0]   line_inc;
    logic [ccrt_pkg::POS_W-1:0]   col_inc;
    logic [ccrt_pkg::OFF_W-1:0]   off_inc;

    // A run holds a token worth reporting.
    assign pending = (run_class_reg >= ccrt_pkg::RUN_IDENT) &&
                     (run_class_reg <= ccrt_pkg::RUN_OPER) &&
                     (run_length_reg != '0);
    assign token_code = run_class_reg - 3'd1;

    // Saturating increments.
    assign len_inc  = (run_length_reg != ccrt_pkg::LEN_MAX) ? run_length_reg + 1'b1
                                                            : ccrt_pkg::LEN_MAX;
    assign line_inc = (cur_line_reg < ccrt_pkg::POS_MAX) ? cur_line_reg + 1'b1
                                                          : ccrt_pkg::POS_MAX;
    assign col_inc  = (cur_col_reg < ccrt_pkg::POS_MAX) ? cur_col_reg + 1'b1
                                                         : ccrt_pkg::POS_MAX;
    assign off_inc  = (byte_off_reg < OFF_LIMIT) ? byte_off_reg + 1'b1
                                                 : OFF_LIMIT;

    // Next state and result for one item.
    always_comb
    begin
        run_class_next  = run_class_reg;
        run_length_next = run_length_reg;
        run_off_next    = run_off_reg;
        run_line_next   = run_line_reg;
        run_col_next    = run_col_reg;
        cur_line_next   = cur_line_reg;
        cur_col_next    = cur_col_reg;
        byte_off_next   = byte_off_reg;

        // Default result is the pending token; emit decides if it goes out.
        res.emit          = 1'b0;
        res.result_kind   = ccrt_pkg::RK_TOKEN;
        res.token_class   = token_code[1:0];
        res.token_length  = run_length_reg;
        res.start_offset  = run_off_reg;
        res.line_number   = run_line_reg;
        res.column_number = run_col_reg;

        if (cls.is_end)
        begin
            // Flush unless halted, then return every position to its start.
            res.emit        = pending;
            run_class_next  = ccrt_pkg::RUN_IDLE;
            run_length_next = '0;
            run_off_next    = '0;
            run_line_next   = ccrt_pkg::POS_ONE;
            run_col_next    = ccrt_pkg::POS_ONE;
            cur_line_next   = ccrt_pkg::POS_ONE;
            cur_col_next    = ccrt_pkg::POS_ONE;
            byte_off_next   = '0;
        end
        else if (run_class_reg == ccrt_pkg::RUN_HALT)
        begin
            // Halted: source bytes are dropped.
        end
        else if (cls.is_newline || cls.is_blank)
        begin
            res.emit        = pending;
            run_class_next  = ccrt_pkg::RUN_IDLE;
            run_length_next = '0;
            if (cls.is_newline)
            begin
                cur_line_next = line_inc;
                cur_col_next  = ccrt_pkg::POS_ONE;
            end
            else
            begin
                cur_col_next = col_inc;
            end
            byte_off_next = off_inc;
        end
        else if (cls.run_code == ccrt_pkg::RUN_IDLE)
        begin
            // Unknown byte: report its position and halt; the run is dropped.
            res.emit          = 1'b1;
            res.result_kind   = ccrt_pkg::RK_ERROR;
            res.token_class   = '0;
            res.token_length  = '0;
            res.start_offset  = '0;
            res.line_number   = cur_line_reg;
            res.column_number = cur_col_reg;
            run_class_next    = ccrt_pkg::RUN_HALT;
            run_length_next   = '0;
        end
        else
        begin
            if ((run_class_reg == cls.run_code) && (run_length_reg != '0))
            begin
                run_length_next = len_inc;
            end
            else
            begin
                // Class change closes the old run and opens a new one here.
                res.emit        = pending;
                run_class_next  = cls.run_code;
                run_length_next = ccrt_pkg::LEN_W'(1);
                run_off_next    = byte_off_reg;
                run_line_next   = cur_line_reg;
                run_col_next    = cur_col_reg;
            end
            cur_col_next  = col_inc;
            byte_off_next = off_inc;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_class_reg  <= ccrt_pkg::RUN_IDLE;
            run_length_reg <= '0;
            run_off_reg    <= '0;
            run_line_reg   <= ccrt_pkg::POS_ONE;
            run_col_reg    <= ccrt_pkg::POS_ONE;
            cur_line_reg   <= ccrt_pkg::POS_ONE;
            cur_col_reg    <= ccrt_pkg::POS_ONE;
            byte_off_reg   <= '0;
        end
        else if (step)
        begin
            run_class_reg  <= run_class_next;
            run_length_reg <= run_length_next;
            run_off_reg    <= run_off_next;
            run_line_reg   <= run_line_next;
            run_col_reg    <= run_col_next;
            cur_line_reg   <= cur_line_next;
            cur_col_reg    <= cur_col_next;
            byte_off_reg   <= byte_off_next;
        end
    end

endmodule

// ----- src/char_class_run_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character-class run tokenizer
// Groups a byte stream into identifier, number, quote and operator tokens
// and reports lexical errors with their line and column.
// ----------------------------------------------------------------------------
// The block takes one request per cycle and gives at most one result per
// request; a request passes through an input register, one step of classify
// and compare logic, and a result register. While a result waits for the
// consumer, the request in the input register is held and in_ready drops once
// that register is full. A token is reported when the byte that closes it
// (blank, newline, class change or end) is processed; after an error result
// the block drops bytes until an end request, which also resets line, column
// and offset.
module char_class_run_tokenizer
#(
    parameter longint MAX_SOURCE_BYTES = ccrt_pkg::MAX_SOURCE_BYTES
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [7:0]                    char_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          result_kind,
    output logic [1:0]                    token_class,
    output logic [ccrt_pkg::LEN_W-1:0]    token_length,
    output logic [ccrt_pkg::OFF_W-1:0]    start_offset,
    output logic [ccrt_pkg::POS_W-1:0]    line_number,
    output logic [ccrt_pkg::POS_W-1:0]    column_number
);

    logic                   in_valid_reg;
    logic                   kind_reg;
    logic [7:0]             byte_reg;
    logic                   out_valid_reg;
    ccrt_pkg::ccrt_result_t out_reg;
    ccrt_pkg::ccrt_class_t  cls;
    ccrt_pkg::ccrt_result_t res;
    logic                   step;
    logic                   in_take;

    // A held request advances when the result register is free or draining.
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;
    assign in_take  = in_valid && in_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= kind;
            byte_reg <= char_byte;
        end
    end

    ccrt_classify u_classify
    (
        .kind      (kind_reg),
        .char_byte (byte_reg),
        .cls       (cls)
    );

    ccrt_core
    #(
        .MAX_SOURCE_BYTES (MAX_SOURCE_BYTES)
    )
    u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cls   (cls),
        .res   (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res.emit)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = out_reg.result_kind;
    assign token_class   = out_reg.token_class;
    assign token_length  = out_reg.token_length;
    assign start_offset  = out_reg.start_offset;
    assign line_number   = out_reg.line_number;
    assign column_number = out_reg.column_number;

`ifndef ASSERT_OFF
    // An error result carries only its position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == ccrt_pkg::RK_ERROR) |->
            (token_class == 2'd0 && token_length == '0 && start_offset == '0))
        else $error("error result carries token fields");

    // A token result always holds at least one byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == ccrt_pkg::RK_TOKEN) |-> (token_length != '0))
        else $error("empty token reported");

    // Line and column count from one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (line_number != '0 && column_number != '0))
        else $error("zero line or column in result");

    // A result is only loaded while a request is being processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !step) |=> !out_valid_reg)
        else $error("result appeared without a request");
`endif

endmodule
